[rtl/core/pfa_pkg.sv]
// Shared types and constants of the partition fit allocator.
package pfa_pkg;

   // Request operation codes
   localparam logic [1:0] OP_BEST    = 2'd0;
   localparam logic [1:0] OP_WORST   = 2'd1;
   localparam logic [1:0] OP_FIRST   = 2'd2;
   localparam logic [1:0] OP_REBUILD = 2'd3;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_COUNT  = 3'd0;
   localparam logic [2:0] REG_SIZE_A = 3'd1;
   localparam logic [2:0] REG_SIZE_B = 3'd2;
   localparam logic [2:0] REG_SIZE_C = 3'd3;
   localparam logic [2:0] REG_SIZE_D = 3'd4;

   localparam int         INIT_SLOTS = 4;
   localparam logic [2:0] MAX_INIT   = 3'd4;
   localparam logic [2:0] RST_COUNT  = 3'd3;
   localparam logic [15:0] RST_SIZE [INIT_SLOTS] = '{16'd100, 16'd200, 16'd50, 16'd0};

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic scan_run;
      logic shift_start;
      logic shift_run;
      logic wr_remain;
      logic grant;
      logic build_start;
      logic build_reset;
      logic build_run;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic found;
      logic split;
      logic full;
      logic shift_done;
      logic build_done;
   } stat_type;

endpackage

[rtl/core/pfa_ram.sv]
// Generic single write port RAM with registered read.
module pfa_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pfa_ctrl.sv]
// Sequencing state machine of the partition fit allocator.
module pfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_operation,
   input  logic              out_free,
   input  pfa_pkg::stat_type stat,
   output logic              req_stall,
   output pfa_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_BUILD, ST_SCAN, ST_DECIDE,
      ST_SHIFT, ST_FIX_REMAIN, ST_FIX_PICK, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      due_ff, due_in;
   logic      do_split;

   assign do_split  = stat.split && !stat.full;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      due_in   = due_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.build_start = 1'b1;
            cmd.build_reset = 1'b1;
            due_in          = 1'b0;
            state_in        = ST_BUILD;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_operation == pfa_pkg::OP_REBUILD) begin
                  cmd.build_start = 1'b1;
                  due_in          = 1'b1;
                  state_in        = ST_BUILD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_BUILD: begin
            cmd.build_run = 1'b1;
            if (stat.build_done) begin
               state_in = due_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!stat.found) begin
               state_in = ST_DONE;
            end else if (do_split) begin
               cmd.shift_start = 1'b1;
               state_in        = ST_SHIFT;
            end else begin
               cmd.grant = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (stat.shift_done) begin
               state_in = ST_FIX_REMAIN;
            end
         end
         ST_FIX_REMAIN: begin
            cmd.wr_remain = 1'b1;
            state_in      = ST_FIX_PICK;
         end
         ST_FIX_PICK: begin
            cmd.grant = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         due_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         due_ff   <= due_in;
      end
   end

endmodule

[rtl/core/pfa_dp.sv]
// Partition table datapath: scan, insert shift, build and result registers.
module pfa_dp #(
   parameter int MAX_ENTRIES = 16,
   parameter int SIZE_BITS   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  pfa_pkg::cmd_type  cmd,
   output pfa_pkg::stat_type stat,
   input  logic [1:0]        req_operation,
   input  logic [15:0]       req_process_tag,
   input  logic [15:0]       req_request_size,
   input  logic [2:0]        cfg_count,
   input  logic [15:0]       cfg_size [pfa_pkg::INIT_SLOTS],
   output logic              res_granted,
   output logic [2:0]        res_partition_number,
   output logic [15:0]       res_process_echo,
   output logic [15:0]       res_granted_amount,
   output logic              res_unsplit_full
);

   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int TOT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int WORD_W = SIZE_BITS + 4;

   // Request
   logic [1:0]           op_ff, op_in;
   logic [15:0]          tag_ff, tag_in;
   logic [SIZE_BITS-1:0] req_ff, req_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   // Scan
   logic [TOT_W-1:0]     scan_ptr_ff, scan_ptr_in;
   logic                 eval_v_ff, eval_v_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [SIZE_BITS-1:0] pick_left_ff, pick_left_in;
   logic [SIZE_BITS-1:0] pick_size_ff, pick_size_in;
   logic [2:0]           pick_label_ff, pick_label_in;
   // Shift
   logic [TOT_W-1:0]     shift_ptr_ff, shift_ptr_in;
   logic                 sh_v_ff, sh_v_in;
   logic [IDX_W-1:0]     sh_dst_ff, sh_dst_in;
   // Build
   logic [2:0]           build_ptr_ff, build_ptr_in;
   logic [2:0]           build_n_ff, build_n_in;
   logic                 build_rst_ff, build_rst_in;
   // Result
   logic                 res_granted_ff, res_granted_in;
   logic [2:0]           res_number_ff, res_number_in;
   logic [15:0]          res_amount_ff, res_amount_in;
   logic                 res_unsplit_ff, res_unsplit_in;

   // Table memory
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   logic [WORD_W-1:0]    wr_data, rd_data;

   logic                 rd_used;
   logic [2:0]           rd_label;
   logic [SIZE_BITS-1:0] rd_size, left;
   logic                 fits, take;
   logic [SIZE_BITS+15:0] req_wide, build_wide, amt_wide;
   logic [15:0]          build_src;
   logic [2:0]           count_src, count_sat;
   logic [TOT_W-1:0]     pick_next, shift_m1;
   logic                 split, full, more_shift;
   logic [SIZE_BITS-1:0] grant_amount;

   pfa_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_used  = rd_data[WORD_W-1];
   assign rd_label = rd_data[WORD_W-2 -: 3];
   assign rd_size  = rd_data[SIZE_BITS-1:0];
   assign left     = rd_size - req_ff;
   assign fits     = !rd_used && (rd_size >= req_ff);
   assign take     = !found_ff
                     || ((op_ff == pfa_pkg::OP_BEST)  && (left < pick_left_ff))
                     || ((op_ff == pfa_pkg::OP_WORST) && (left > pick_left_ff));

   assign split      = pick_size_ff > req_ff;
   assign full       = (total_ff == TOT_W'(MAX_ENTRIES));
   assign pick_next  = TOT_W'(pick_ff) + TOT_W'(1);
   assign shift_m1   = shift_ptr_ff - TOT_W'(1);
   assign more_shift = shift_ptr_ff > pick_next;

   assign req_wide     = {{SIZE_BITS{1'b0}}, req_request_size};
   assign build_src    = build_rst_ff ? pfa_pkg::RST_SIZE[build_ptr_ff[1:0]]
                                      : cfg_size[build_ptr_ff[1:0]];
   assign build_wide   = {{SIZE_BITS{1'b0}}, build_src};
   assign count_src    = cmd.build_reset ? pfa_pkg::RST_COUNT : cfg_count;
   assign count_sat    = (count_src > pfa_pkg::MAX_INIT) ? pfa_pkg::MAX_INIT : count_src;
   assign grant_amount = (split && !full) ? req_ff : pick_size_ff;
   assign amt_wide     = {16'd0, grant_amount};

   always_comb begin
      op_in          = op_ff;
      tag_in         = tag_ff;
      req_in         = req_ff;
      total_in       = total_ff;
      scan_ptr_in    = scan_ptr_ff;
      eval_v_in      = 1'b0;
      eval_idx_in    = eval_idx_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      pick_left_in   = pick_left_ff;
      pick_size_in   = pick_size_ff;
      pick_label_in  = pick_label_ff;
      shift_ptr_in   = shift_ptr_ff;
      sh_v_in        = 1'b0;
      sh_dst_in      = sh_dst_ff;
      build_ptr_in   = build_ptr_ff;
      build_n_in     = build_n_ff;
      build_rst_in   = build_rst_ff;
      res_granted_in = res_granted_ff;
      res_number_in  = res_number_ff;
      res_amount_in  = res_amount_ff;
      res_unsplit_in = res_unsplit_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      rd_addr        = scan_ptr_ff[IDX_W-1:0];

      if (cmd.load_req) begin
         op_in          = req_operation;
         tag_in         = req_process_tag;
         req_in         = req_wide[SIZE_BITS-1:0];
         scan_ptr_in    = '0;
         found_in       = 1'b0;
         res_granted_in = 1'b0;
         res_number_in  = '0;
         res_amount_in  = '0;
         res_unsplit_in = 1'b0;
      end

      // Read one entry a cycle; judge it when its data returns
      if (cmd.scan_run && (scan_ptr_ff != total_ff)) begin
         eval_v_in   = 1'b1;
         eval_idx_in = scan_ptr_ff[IDX_W-1:0];
         scan_ptr_in = scan_ptr_ff + TOT_W'(1);
      end
      if (eval_v_ff && fits && take) begin
         found_in      = 1'b1;
         pick_in       = eval_idx_ff;
         pick_left_in  = left;
         pick_size_in  = rd_size;
         pick_label_in = rd_label;
      end

      // Move entries up by one, top first
      if (cmd.shift_start) begin
         shift_ptr_in = total_ff;
      end
      if (cmd.shift_run && more_shift) begin
         rd_addr      = shift_m1[IDX_W-1:0];
         sh_v_in      = 1'b1;
         sh_dst_in    = shift_ptr_ff[IDX_W-1:0];
         shift_ptr_in = shift_m1;
      end
      if (sh_v_ff) begin
         wr_en   = 1'b1;
         wr_addr = sh_dst_ff;
         wr_data = rd_data;
      end

      if (cmd.wr_remain) begin
         wr_en   = 1'b1;
         wr_addr = pick_next[IDX_W-1:0];
         wr_data = {1'b0, pick_label_ff, pick_size_ff - req_ff};
      end

      if (cmd.grant) begin
         wr_en          = 1'b1;
         wr_addr        = pick_ff;
         wr_data        = {1'b1, pick_label_ff, grant_amount};
         res_granted_in = 1'b1;
         res_number_in  = pick_label_ff;
         res_amount_in  = amt_wide[15:0];
         if (split && !full) begin
            total_in = total_ff + TOT_W'(1);
         end else begin
            res_unsplit_in = split;
         end
      end

      if (cmd.build_start) begin
         build_ptr_in = '0;
         build_n_in   = count_sat;
         build_rst_in = cmd.build_reset;
         total_in     = TOT_W'(count_sat);
      end
      if (cmd.build_run && (build_ptr_ff != build_n_ff)) begin
         wr_en        = 1'b1;
         wr_addr      = IDX_W'(build_ptr_ff[1:0]);
         wr_data      = {1'b0, build_ptr_ff + 3'd1, build_wide[SIZE_BITS-1:0]};
         build_ptr_in = build_ptr_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         scan_ptr_ff  <= '0;
         eval_v_ff    <= 1'b0;
         found_ff     <= 1'b0;
         sh_v_ff      <= 1'b0;
         shift_ptr_ff <= '0;
         build_ptr_ff <= '0;
         build_n_ff   <= '0;
         build_rst_ff <= 1'b1;
      end else begin
         total_ff     <= total_in;
         scan_ptr_ff  <= scan_ptr_in;
         eval_v_ff    <= eval_v_in;
         found_ff     <= found_in;
         sh_v_ff      <= sh_v_in;
         shift_ptr_ff <= shift_ptr_in;
         build_ptr_ff <= build_ptr_in;
         build_n_ff   <= build_n_in;
         build_rst_ff <= build_rst_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      tag_ff         <= tag_in;
      req_ff         <= req_in;
      eval_idx_ff    <= eval_idx_in;
      pick_ff        <= pick_in;
      pick_left_ff   <= pick_left_in;
      pick_size_ff   <= pick_size_in;
      pick_label_ff  <= pick_label_in;
      sh_dst_ff      <= sh_dst_in;
      res_granted_ff <= res_granted_in;
      res_number_ff  <= res_number_in;
      res_amount_ff  <= res_amount_in;
      res_unsplit_ff <= res_unsplit_in;
   end

   assign stat.scan_done  = (scan_ptr_ff == total_ff) && !eval_v_ff;
   assign stat.found      = found_ff;
   assign stat.split      = split;
   assign stat.full       = full;
   assign stat.shift_done = !more_shift && !sh_v_ff;
   assign stat.build_done = (build_ptr_ff == build_n_ff);

   assign res_granted          = res_granted_ff;
   assign res_partition_number = res_number_ff;
   assign res_process_echo     = tag_ff;
   assign res_granted_amount   = res_amount_ff;
   assign res_unsplit_full     = res_unsplit_ff;

endmodule

[rtl/core/partition_fit_allocator.sv]
// Top level of the partition fit allocator: register file, output register, core.
//
// Usage
//  - Request channel (req_*): operation (best, worst or first fit, or rebuild),
//    process tag and requested size. A transfer happens when req_valid is high
//    and req_stall is low; the block takes one request at a time.
//  - Result channel (rsp_*): exactly one result per request, held in an output
//    register until the receiver takes it. While rsp_stall is high the result
//    holds; the block may already take the next request meanwhile.
//  - APB-style register port at byte addresses 0 (initial count) and 4..16
//    (initial sizes a..d). Writes take effect at the next rebuild.
// Sequence, n = entries in the table
//  - Fit request: a scan of the n entries (one table read per cycle through the
//    single read port), a decision, and on a split a shift of the entries above
//    the chosen one up by one plus two writes (remainder, then chosen entry);
//    last the result is loaded into the output register once that is free.
//  - Rebuild: one table write per configured entry, then the result is loaded.
// Reset: synchronous. The table is built from the reset configuration in a
//  pass (start, three writes, finish); req_stall stays high until done.
module partition_fit_allocator #(
   parameter int MAX_ENTRIES = 16,
   parameter int SIZE_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_process_tag,
   input  logic [15:0] req_request_size,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [2:0]  rsp_partition_number,
   output logic [15:0] rsp_process_echo,
   output logic [15:0] rsp_granted_amount,
   output logic        rsp_unsplit_full,
   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   pfa_pkg::cmd_type  cmd;
   pfa_pkg::stat_type stat;

   // Configuration registers
   logic [2:0]  count_ff, count_in;
   logic [15:0] size_ff [pfa_pkg::INIT_SLOTS];
   logic [15:0] size_in [pfa_pkg::INIT_SLOTS];
   logic        cfg_wr;
   logic [2:0]  cfg_idx;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_granted_ff;
   logic [2:0]  out_number_ff;
   logic [15:0] out_echo_ff;
   logic [15:0] out_amount_ff;
   logic        out_unsplit_ff;
   logic        out_free;

   logic        res_granted;
   logic [2:0]  res_partition_number;
   logic [15:0] res_process_echo;
   logic [15:0] res_granted_amount;
   logic        res_unsplit_full;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[4:2];

   // Register writes: an index beyond the list is dropped
   always_comb begin
      count_in = count_ff;
      size_in  = size_ff;
      if (cfg_wr) begin
         case (cfg_idx)
            pfa_pkg::REG_COUNT:  count_in   = pwdata[2:0];
            pfa_pkg::REG_SIZE_A: size_in[0] = pwdata[15:0];
            pfa_pkg::REG_SIZE_B: size_in[1] = pwdata[15:0];
            pfa_pkg::REG_SIZE_C: size_in[2] = pwdata[15:0];
            pfa_pkg::REG_SIZE_D: size_in[3] = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         pfa_pkg::REG_COUNT:  prdata = {29'd0, count_ff};
         pfa_pkg::REG_SIZE_A: prdata = {16'd0, size_ff[0]};
         pfa_pkg::REG_SIZE_B: prdata = {16'd0, size_ff[1]};
         pfa_pkg::REG_SIZE_C: prdata = {16'd0, size_ff[2]};
         pfa_pkg::REG_SIZE_D: prdata = {16'd0, size_ff[3]};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= pfa_pkg::RST_COUNT;
         size_ff  <= pfa_pkg::RST_SIZE;
      end else begin
         count_ff <= count_in;
         size_ff  <= size_in;
      end
   end

   // The output slot is free when empty or when its transfer completes now
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_granted_ff <= res_granted;
         out_number_ff  <= res_partition_number;
         out_echo_ff    <= res_process_echo;
         out_amount_ff  <= res_granted_amount;
         out_unsplit_ff <= res_unsplit_full;
      end
   end

   pfa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .out_free      (out_free),
      .stat          (stat),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   pfa_dp #(.MAX_ENTRIES(MAX_ENTRIES), .SIZE_BITS(SIZE_BITS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_operation        (req_operation),
      .req_process_tag      (req_process_tag),
      .req_request_size     (req_request_size),
      .cfg_count            (count_ff),
      .cfg_size             (size_ff),
      .res_granted          (res_granted),
      .res_partition_number (res_partition_number),
      .res_process_echo     (res_process_echo),
      .res_granted_amount   (res_granted_amount),
      .res_unsplit_full     (res_unsplit_full)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_granted          = out_granted_ff;
   assign rsp_partition_number = out_number_ff;
   assign rsp_process_echo     = out_echo_ff;
   assign rsp_granted_amount   = out_amount_ff;
   assign rsp_unsplit_full     = out_unsplit_ff;

endmodule

[rtl/core/pfa_checker.sv]
// Port-level checks of the partition fit allocator and their bind.
module pfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_granted,
   input logic [2:0]  rsp_partition_number,
   input logic [15:0] rsp_process_echo,
   input logic [15:0] rsp_granted_amount,
   input logic        rsp_unsplit_full
);

   // A stalled result stays valid and holds its tag, grant flag and amount
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_process_echo)
         && $stable(rsp_granted) && $stable(rsp_granted_amount))
      else $error("stalled result changed");

   // A refusal carries no partition, amount or flag
   a_refusal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> (rsp_partition_number == 3'd0)
         && (rsp_granted_amount == 16'd0) && !rsp_unsplit_full)
      else $error("refusal with payload");

   // A grant names one of the four partitions
   a_grant_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> (rsp_partition_number != 3'd0)
         && (rsp_partition_number <= 3'd4))
      else $error("grant with bad partition id");

   // One request at a time: busy right after a transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_granted          (rsp_granted),
   .rsp_partition_number (rsp_partition_number),
   .rsp_process_echo     (rsp_process_echo),
   .rsp_granted_amount   (rsp_granted_amount),
   .rsp_unsplit_full     (rsp_unsplit_full)
);
